>>> rtl/core/command_line_tokenizer_defines.svh
// ----------------------------------------------------------------------------
// Tokenizer assertion macros
// Concurrent check wrappers; empty bodies when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef COMMAND_LINE_TOKENIZER_DEFINES_SVH
`define COMMAND_LINE_TOKENIZER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CLT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define CLT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CLT_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define CLT_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif

`endif

>>> rtl/core/cltok_pkg.sv
// ----------------------------------------------------------------------------
// Tokenizer package
// Shared types, codes and defaults of the command line tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cltok_pkg;

  localparam int ARG_SLOTS_DEF = 16;
  localparam int ARG_BYTES_DEF = 256;

  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic ERR_TOO_LONG = 1'b0;
  localparam logic ERR_TOO_MANY = 1'b1;

  typedef enum logic [2:0] {
    MODE_LINE,
    MODE_COMMENT,
    MODE_ARG,
    MODE_GAP,
    MODE_ERROR
  } mode_t;

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_CLOSE,
    KIND_DONE,
    KIND_ERROR
  } kind_t;

  typedef struct packed {
    logic       op;
    logic [7:0] text_byte;
  } item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_byte;
    logic [3:0] arg_index;
    logic [7:0] char_index;
    logic [4:0] arg_total;
    logic       error_code;
  } result_t;

endpackage

>>> rtl/core/cltok_in_if.sv
// ----------------------------------------------------------------------------
// Text channel
// Valid/ready channel carrying one text word (op and byte).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cltok_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] text_byte;

  modport source (output valid, op, text_byte, input ready);
  modport sink   (input valid, op, text_byte, output ready);
endinterface

>>> rtl/core/cltok_out_if.sv
// ----------------------------------------------------------------------------
// Token channel
// Valid/ready channel carrying one token word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cltok_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [3:0] arg_index;
  logic [7:0] char_index;
  logic [4:0] arg_total;
  logic       error_code;

  modport source (output valid, kind, out_byte, arg_index, char_index, arg_total,
                  error_code, input ready);
  modport sink   (input valid, kind, out_byte, arg_index, char_index, arg_total,
                  error_code, output ready);
endinterface

>>> rtl/core/cltok_in_reg.sv
// ----------------------------------------------------------------------------
// Tokenizer input register
// Holds one text word until the parser consumes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cltok_in_reg (
  input  logic            clk,
  input  logic            rst,
  cltok_in_if.sink        text,
  input  logic            advance,
  output logic            held,
  output cltok_pkg::item_t item
);
  import cltok_pkg::*;

  logic  held_next;
  item_t item_next;

  // free slot, or the held word leaves this cycle
  assign text.ready = !held || advance;

  always_comb begin
    held_next = held && !advance;
    item_next = item;
    if (text.valid && text.ready) begin
      held_next = 1'b1;
      item_next = '{op: text.op, text_byte: text.text_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    item <= item_next;
  end

endmodule

>>> rtl/core/cltok_parser.sv
// ----------------------------------------------------------------------------
// Tokenizer parser
// Mode and counter registers with the single-pass step logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "command_line_tokenizer_defines.svh"

module cltok_parser #(
  parameter int ARG_SLOTS = cltok_pkg::ARG_SLOTS_DEF,
  parameter int ARG_BYTES = cltok_pkg::ARG_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  cltok_pkg::item_t   item,
  output logic               has_result,
  output cltok_pkg::result_t result
);
  import cltok_pkg::*;

  localparam int AW = $clog2(ARG_SLOTS);
  localparam int CW = $clog2(ARG_BYTES);
  localparam logic [AW-1:0] SLOT_LAST = AW'(ARG_SLOTS - 1);
  localparam logic [CW-1:0] BYTE_LAST = CW'(ARG_BYTES - 1);

  mode_t         mode, mode_next;
  logic [AW-1:0] arg_count, arg_count_next;
  logic [CW-1:0] char_count, char_count_next;

  logic       blank, newline;
  logic [7:0] c;
  logic [3:0] ai_out;
  logic [7:0] ci_out;
  logic [4:0] total_out;
  logic [AW:0] total;
  logic [AW+3:0] ai_pad;
  logic [CW+7:0] ci_pad;
  logic [AW+5:0] total_pad;

  mode_t         app_mode;
  logic [CW-1:0] app_count;
  result_t       app_res, done_res;

  assign c       = item.text_byte;
  assign newline = (c == CHAR_NL);
  assign blank   = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));

  // fit counters to the output fields (zero-extend, then low bits)
  assign ai_pad    = {4'b0, arg_count};
  assign ci_pad    = {8'b0, char_count};
  assign total     = {1'b0, arg_count} + (AW+1)'(mode == MODE_ARG);
  assign total_pad = {5'b0, total};
  assign ai_out    = ai_pad[3:0];
  assign ci_out    = ci_pad[7:0];
  assign total_out = total_pad[4:0];

  // append a byte to the open argument, or flag it too long
  always_comb begin
    app_res = '0;
    app_res.arg_index  = ai_out;
    app_res.char_index = ci_out;
    if (char_count == BYTE_LAST) begin
      app_mode           = MODE_ERROR;
      app_count          = char_count;
      app_res.kind       = KIND_ERROR;
      app_res.error_code = ERR_TOO_LONG;
    end else begin
      app_mode         = MODE_ARG;
      app_count        = char_count + CW'(1);
      app_res.kind     = KIND_BYTE;
      app_res.out_byte = c;
    end
  end

  // command completion
  always_comb begin
    done_res = '0;
    done_res.kind       = KIND_DONE;
    done_res.char_index = (mode == MODE_ARG) ? ci_out : 8'd0;
    done_res.arg_total  = total_out;
  end

  always_comb begin
    mode_next       = mode;
    arg_count_next  = arg_count;
    char_count_next = char_count;
    has_result      = 1'b0;
    result          = app_res;
    if (!fire) begin
      has_result = 1'b0;
    end else if (item.op == OP_END) begin
      has_result      = (mode == MODE_ARG) || (mode == MODE_GAP);
      result          = done_res;
      mode_next       = MODE_LINE;
      arg_count_next  = '0;
      char_count_next = '0;
    end else if (c != CHAR_NUL) begin
      case (mode)
        MODE_LINE: begin
          if (c == CHAR_HASH) begin
            mode_next = MODE_COMMENT;
          end else if (!blank) begin
            has_result      = 1'b1;
            mode_next       = app_mode;
            char_count_next = app_count;
          end
        end
        MODE_COMMENT: begin
          if (newline) mode_next = MODE_LINE;
        end
        MODE_ARG, MODE_GAP: begin
          if (newline) begin
            has_result      = 1'b1;
            result          = done_res;
            mode_next       = MODE_LINE;
            arg_count_next  = '0;
            char_count_next = '0;
          end else if (!blank) begin
            has_result      = 1'b1;
            mode_next       = app_mode;
            char_count_next = app_count;
          end else if (mode == MODE_ARG) begin
            has_result      = 1'b1;
            result.out_byte = 8'd0;
            if (arg_count == SLOT_LAST) begin
              mode_next         = MODE_ERROR;
              result.kind       = KIND_ERROR;
              result.error_code = ERR_TOO_MANY;
            end else begin
              // close the argument with its length
              mode_next       = MODE_GAP;
              arg_count_next  = arg_count + AW'(1);
              char_count_next = '0;
              result.kind     = KIND_CLOSE;
            end
          end
        end
        default: begin
          mode_next = mode;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_LINE;
      arg_count  <= '0;
      char_count <= '0;
    end else begin
      mode       <= mode_next;
      arg_count  <= arg_count_next;
      char_count <= char_count_next;
    end
  end

  `CLT_ASSERT_NXT(a_end_restarts, clk, rst, fire && (item.op == OP_END),
    (mode == MODE_LINE) && (arg_count == '0) && (char_count == '0),
    "end of text did not restart the parser")
  `CLT_ASSERT_IMP(a_error_silent, clk, rst,
    fire && (mode == MODE_ERROR) && (item.op == OP_BYTE), !has_result,
    "result produced in error mode")
  `CLT_ASSERT_IMP(a_line_counts_clear, clk, rst,
    (mode == MODE_LINE) || (mode == MODE_COMMENT),
    (arg_count == '0) && (char_count == '0),
    "counts not clear at line start or in a comment")

endmodule

>>> rtl/core/cltok_out_reg.sv
// ----------------------------------------------------------------------------
// Tokenizer result register
// Holds one token word until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cltok_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic               has_result,
  input  cltok_pkg::result_t result,
  output logic               space,
  cltok_out_if.source        token
);
  import cltok_pkg::*;

  logic    full, full_next;
  result_t data, data_next;

  assign space = !full || token.ready;

  always_comb begin
    full_next = space ? (load && has_result) : full;
    data_next = (space && load && has_result) ? result : data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= full_next;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  assign token.valid      = full;
  assign token.kind       = data.kind;
  assign token.out_byte   = data.out_byte;
  assign token.arg_index  = data.arg_index;
  assign token.char_index = data.char_index;
  assign token.arg_total  = data.arg_total;
  assign token.error_code = data.error_code;

endmodule

>>> rtl/core/command_line_tokenizer.sv
// ----------------------------------------------------------------------------
// Command line tokenizer
// Splits a byte stream into whitespace-separated arguments and commands.
// ----------------------------------------------------------------------------
// Usage:
//   text  : sink channel, one word per byte (op = byte) or end of text
//           (op = end, byte ignored). End of text flushes an open command
//           and returns to line start.
//   token : source channel, at most one word per text word: argument byte,
//           argument closed (with length), command complete (with count)
//           or error (too long / too many arguments).
// Flow: a text word is taken into the input register, parsed there by the
//   combinational parser, and its token is held in the result register.
// Throughput: one text word per cycle while the token register is not
//   stalled; the only loop is the mode/counter register update.
// Stall: while the token register is full and not taken, the parser holds;
//   text.ready drops once the input register holds a word; nothing is lost.
//   Words that give no token (blanks, comments, NUL, dropped bytes after an
//   error) wait in the same way.
// Reset: synchronous; both registers empty, parser at line start, counts 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "command_line_tokenizer_defines.svh"

module command_line_tokenizer #(
  parameter int ARG_SLOTS = cltok_pkg::ARG_SLOTS_DEF,
  parameter int ARG_BYTES = cltok_pkg::ARG_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  cltok_in_if.sink    text,
  cltok_out_if.source token
);
  import cltok_pkg::*;

  logic    held;      // input register holds a word
  logic    space;     // result register can take a word this cycle
  logic    advance;   // parser step
  logic    has_result;
  item_t   item;
  result_t result;

  assign advance = held && space;

  cltok_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .text    (text),
    .advance (advance),
    .held    (held),
    .item    (item)
  );

  cltok_parser #(
    .ARG_SLOTS (ARG_SLOTS),
    .ARG_BYTES (ARG_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .fire       (advance),
    .item       (item),
    .has_result (has_result),
    .result     (result)
  );

  cltok_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (advance),
    .has_result (has_result),
    .result     (result),
    .space      (space),
    .token      (token)
  );

  // back-pressure only comes from a stalled token word
  `CLT_ASSERT_IMP(a_stall_source, clk, rst, !text.ready,
    held && token.valid && !token.ready, "text stalled without token stall")

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// Command line tokenizer testbench
// Streams text words into the tokenizer and predicts every token word
// (argument byte, argument closed, command complete, error) with an
// independent parser model. Each token taken from the block is checked field
// by field against the oldest predicted one. Both channels idle at random,
// and the token side is held off for a long stretch once so that the block
// backs up into the text channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import cltok_pkg::*;

  localparam int ARG_SLOTS    = ARG_SLOTS_DEF;
  localparam int ARG_BYTES    = ARG_BYTES_DEF;
  localparam int RANDOM_WORDS = 1200;
  localparam int HOLD_CYCLES  = 300;    // long token-side hold-off
  localparam int DRAIN_LIMIT  = 5000;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int PRINT_LIMIT  = 50;

  // Blanks with no name in the package
  localparam logic [7:0] CHAR_VT = 8'h0B;
  localparam logic [7:0] CHAR_FF = 8'h0C;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cltok_in_if  text_ch();
  cltok_out_if token_ch();

  command_line_tokenizer #(
    .ARG_SLOTS(ARG_SLOTS),
    .ARG_BYTES(ARG_BYTES)
  ) u_dut (
    .clk  (clk),
    .rst  (rst),
    .text (text_ch),
    .token(token_ch)
  );

  // Expected token words, oldest first
  result_t pending_tokens[$];

  int  mismatches  = 0;
  int  words_sent  = 0;
  int  parsed_words = 0;  // words taken while not in error mode
  int  cycles      = 0;
  int  calm[2]     = '{0, 0};  // per side: gap picks left with no idling
  bit  no_gaps     = 1'b0;
  bit  hold_req    = 1'b0;

  // Parser state of the prediction
  mode_t tok_mode;
  int    tok_args;
  int    tok_len;

  // --------------------------------------------------------------------------
  // Clock and cycle limit
  // --------------------------------------------------------------------------
  initial begin
    forever #6 clk = ~clk;
  end

  // Watchdog: a hang anywhere ends here.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_LIMIT) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  // Mostly back to back, some short gaps, a few long ones, and now and then a
  // calm stretch with no gaps at all.
  function automatic int pick_gap(input int side);
    int r;
    if (calm[side] > 0) begin
      calm[side]--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm[side] = $urandom_range(20, 80);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  // Non-blank, non-NUL character; '#' is favored since it means something
  // at line start.
  function automatic logic [7:0] word_char();
    logic [7:0] c;
    if ($urandom_range(0, 15) == 0) return CHAR_HASH;
    do c = 8'($urandom_range(1, 255)); while (is_blank(c));
    return c;
  endfunction

  // Blank other than newline
  function automatic logic [7:0] sep_char();
    case ($urandom_range(0, 4))
      0: return CHAR_SPACE;
      1: return CHAR_TAB;
      2: return CHAR_VT;
      3: return CHAR_FF;
      default: return CHAR_CR;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Token prediction
  // --------------------------------------------------------------------------
  task automatic push_token(input kind_t k, input logic [7:0] b, input int ai,
                            input int ci, input int tot, input logic code);
    result_t r;
    r.kind       = k;
    r.out_byte   = b;
    r.arg_index  = ai[3:0];
    r.char_index = ci[7:0];
    r.arg_total  = tot[4:0];
    r.error_code = code;
    pending_tokens.push_back(r);
  endtask

  task automatic clear_parser();
    tok_mode = MODE_LINE;
    tok_args = 0;
    tok_len  = 0;
  endtask

  // Add a character to the open argument, or flag it too long.
  task automatic add_char(input logic [7:0] c);
    if (tok_len + 1 >= ARG_BYTES) begin
      tok_mode = MODE_ERROR;
      push_token(KIND_ERROR, 8'h00, tok_args, tok_len, 0, ERR_TOO_LONG);
    end else begin
      push_token(KIND_BYTE, c, tok_args, tok_len, 0, 1'b0);
      tok_len++;
      tok_mode = MODE_ARG;
    end
  endtask

  // Close the command; an open argument counts toward the total.
  task automatic finish_command();
    int total;
    int len;
    total = tok_args;
    len   = 0;
    if (tok_mode == MODE_ARG) begin
      total++;
      len = tok_len;
    end
    clear_parser();
    push_token(KIND_DONE, 8'h00, 0, len, total, 1'b0);
  endtask

  task automatic predict_tokens(input logic op, input logic [7:0] c);
    if (op == OP_END) begin
      if (tok_mode == MODE_ARG || tok_mode == MODE_GAP) finish_command();
      else clear_parser();
    end else if (c != CHAR_NUL) begin
      case (tok_mode)
        MODE_LINE: begin
          if (c == CHAR_HASH) tok_mode = MODE_COMMENT;
          else if (!is_blank(c)) add_char(c);
        end
        MODE_COMMENT: begin
          if (c == CHAR_NL) tok_mode = MODE_LINE;
        end
        MODE_ARG: begin
          if (c == CHAR_NL) begin
            finish_command();
          end else if (!is_blank(c)) begin
            add_char(c);
          end else if (tok_args + 1 >= ARG_SLOTS) begin
            tok_mode = MODE_ERROR;
            push_token(KIND_ERROR, 8'h00, tok_args, tok_len, 0, ERR_TOO_MANY);
          end else begin
            push_token(KIND_CLOSE, 8'h00, tok_args, tok_len, 0, 1'b0);
            tok_args++;
            tok_len  = 0;
            tok_mode = MODE_GAP;
          end
        end
        MODE_GAP: begin
          if (c == CHAR_NL) finish_command();
          else if (!is_blank(c)) add_char(c);
        end
        default: ;  // error mode drops everything
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Text side: one word per call. valid stays high after the handshake so
  // that back-to-back words follow without a break; within a call only a gap lowers it.
  // --------------------------------------------------------------------------
  task automatic send_word(input logic op, input logic [7:0] b);
    int gap;
    gap = no_gaps ? 0 : pick_gap(0);
    if (gap > 0) begin
      text_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_ch.valid     <= 1'b1;
    text_ch.op        <= op;
    text_ch.text_byte <= b;
    @(posedge clk);
    while (!text_ch.ready) @(posedge clk);
    if (tok_mode != MODE_ERROR) parsed_words++;
    predict_tokens(op, b);
    words_sent++;
  endtask

  task automatic send_end();
    // byte field is don't-care on end of text; keep it random
    send_word(OP_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(OP_BYTE, s[i]);
  endtask

  task automatic send_seps(input int n);
    repeat (n) send_word(OP_BYTE, sep_char());
  endtask

  // One argument of len characters, with a stray NUL now and then
  task automatic send_arg(input int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 32) == 0) send_word(OP_BYTE, CHAR_NUL);
      send_word(OP_BYTE, word_char());
    end
  endtask

  // Park the text channel and wait for every predicted token to come out,
  // then give in-flight words time to pass the two-stage pipe.
  task automatic wait_drained();
    int waited;
    waited = 0;
    text_ch.valid <= 1'b0;
    while (pending_tokens.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_tokens.size() != 0) begin
      report_mismatch($sformatf("%0d token words never arrived",
                                pending_tokens.size()));
      pending_tokens.delete();
    end
    repeat (10) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Token side: random ready with occasional stalls; a hold request from a
  // test turns into one long stall counted here.
  // --------------------------------------------------------------------------
  initial begin
    int stall_left;
    int gap;
    stall_left     = 0;
    token_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        token_ch.ready <= 1'b0;
        stall_left--;
      end else if (hold_req) begin
        hold_req       = 1'b0;
        stall_left     = HOLD_CYCLES - 1;
        token_ch.ready <= 1'b0;
      end else begin
        gap = pick_gap(1);
        if (gap > 0) begin
          token_ch.ready <= 1'b0;
          stall_left     = gap - 1;
        end else begin
          token_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Token checker: every word taken is matched against the oldest prediction.
  initial begin
    result_t exp_tok;
    forever begin
      @(posedge clk);
      if (!rst && token_ch.valid && token_ch.ready) begin
        if (pending_tokens.size() == 0) begin
          report_mismatch($sformatf("unexpected token kind=%0d byte=%02h",
                                    token_ch.kind, token_ch.out_byte));
        end else begin
          exp_tok = pending_tokens.pop_front();
          if (token_ch.kind !== exp_tok.kind)
            report_mismatch($sformatf("kind %0d, expected %0d",
                                      token_ch.kind, exp_tok.kind));
          if (token_ch.out_byte !== exp_tok.out_byte)
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      token_ch.out_byte, exp_tok.out_byte));
          if (token_ch.arg_index !== exp_tok.arg_index)
            report_mismatch($sformatf("arg_index %0d, expected %0d",
                                      token_ch.arg_index, exp_tok.arg_index));
          if (token_ch.char_index !== exp_tok.char_index)
            report_mismatch($sformatf("char_index %0d, expected %0d",
                                      token_ch.char_index, exp_tok.char_index));
          if (token_ch.arg_total !== exp_tok.arg_total)
            report_mismatch($sformatf("arg_total %0d, expected %0d",
                                      token_ch.arg_total, exp_tok.arg_total));
          if (token_ch.error_code !== exp_tok.error_code)
            report_mismatch($sformatf("error_code %0d, expected %0d",
                                      token_ch.error_code, exp_tok.error_code));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Short hand-made text through line, comment, argument and gap modes: blanks,
  // comments, NUL, high bytes, '#' inside and after an argument, blanks at line
  // start, as separators and trailing, and end of text from each of those modes.
  task automatic test_basic_modes();
    send_end();                         // at line start: no token
    send_word(OP_BYTE, CHAR_NUL);       // ignored
    send_text("\t #x\n");               // comment line
    send_text("a");
    send_word(OP_BYTE, 8'h80);
    send_word(OP_BYTE, 8'hFF);
    send_word(OP_BYTE, CHAR_HASH);      // plain char inside an argument
    send_word(OP_BYTE, CHAR_NUL);
    send_word(OP_BYTE, CHAR_VT);        // closes, length 4
    send_word(OP_BYTE, CHAR_HASH);      // starts an argument from a gap
    send_word(OP_BYTE, CHAR_FF);
    send_word(OP_BYTE, CHAR_CR);
    send_word(OP_BYTE, CHAR_NL);        // trailing blanks: no empty argument
    send_word(OP_BYTE, 8'h01);
    send_end();                         // completes with the open argument
    send_text("y ");
    send_end();                         // completes from a gap
    send_text("#c");
    send_end();                         // in a comment: no token
    send_text(" \n");
  endtask

  // Longest legal argument, then one byte more; error mode then swallows
  // newlines until end of text.
  task automatic test_long_argument();
    send_arg(ARG_BYTES - 1);
    send_word(OP_BYTE, CHAR_SPACE);
    send_arg(ARG_BYTES);
    send_text("gone\n");
    send_word(OP_BYTE, CHAR_NL);
    send_end();
  endtask

  // A full command ended by newline is fine; closing one argument too many
  // with a blank is an error.
  task automatic test_argument_count();
    for (int k = 0; k < ARG_SLOTS - 1; k++) begin
      send_arg(1);
      send_word(OP_BYTE, sep_char());
    end
    send_text("p\n");
    for (int k = 0; k < ARG_SLOTS; k++) begin
      send_arg(2);
      send_word(OP_BYTE, sep_char());
    end
    send_text("dropped\n");
    send_end();
  endtask

  // Token side held off while text keeps coming back to back, so the block
  // must fill and drop text ready.
  task automatic test_token_hold();
    hold_req = 1'b1;
    no_gaps  = 1'b1;
    send_text("fill the pipe while held\n");
    send_text("x y z\n");
    no_gaps  = 1'b0;
  endtask

  // Text stops until every token is out, then picks up mid-command.
  task automatic test_sender_pause();
    send_text("half ");
    wait_drained();
    send_text("done\n");
  endtask

  // Mostly well-formed commands with random content, plus comments, noise
  // and the odd oversize argument or argument count.
  task automatic test_random_commands();
    int start;
    int r;
    int nargs;
    int len;
    start = parsed_words;
    while (parsed_words - start < RANDOM_WORDS) begin
      if (tok_mode == MODE_ERROR && $urandom_range(0, 3) != 0) send_end();
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_word(OP_BYTE, CHAR_HASH);
        repeat ($urandom_range(0, 10)) send_word(OP_BYTE, 8'($urandom_range(0, 255)));
        send_word(OP_BYTE, CHAR_NL);
      end else if (r < 14) begin
        repeat ($urandom_range(1, 16)) begin
          if ($urandom_range(0, 9) == 0) send_end();
          else send_word(OP_BYTE, 8'($urandom_range(0, 255)));
        end
      end else begin
        if ($urandom_range(0, 3) == 0) send_seps($urandom_range(1, 3));
        nargs = ($urandom_range(0, 99) < 6) ? $urandom_range(ARG_SLOTS - 2, ARG_SLOTS + 1)
                                            : $urandom_range(0, 6);
        for (int k = 0; k < nargs; k++) begin
          if (k > 0) send_seps($urandom_range(1, 3));
          len = ($urandom_range(0, 79) == 0) ? $urandom_range(ARG_BYTES - 3, ARG_BYTES + 1)
                                             : $urandom_range(1, 8);
          send_arg(len);
        end
        if ($urandom_range(0, 3) == 0) send_seps($urandom_range(1, 2));
        r = $urandom_range(0, 99);
        if (r < 80) send_word(OP_BYTE, CHAR_NL);
        else if (r < 95) send_end();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    text_ch.valid     <= 1'b0;
    text_ch.op        <= OP_BYTE;
    text_ch.text_byte <= CHAR_NUL;
    clear_parser();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_modes();
    test_long_argument();
    test_argument_count();
    test_token_hold();
    test_sender_pause();
    test_random_commands();
    send_end();

    wait_drained();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/cltok_pkg.sv
rtl/core/cltok_in_if.sv
rtl/core/cltok_out_if.sv
rtl/core/cltok_in_reg.sv
rtl/core/cltok_parser.sv
rtl/core/cltok_out_reg.sv
rtl/core/command_line_tokenizer.sv
bench/tb.sv
